// ===== src/tcsam_pkg.sv =====
// shared types and constants for the type-c source attach monitor
// no dependencies; used by the decision logic and the top level
package tcsam_pkg;

   localparam int unsigned LevelW = 2;
   localparam int unsigned ModeW = 2;

   typedef enum logic [2:0] {
      ST_INIT         = 3'd0,
      ST_DETACHED     = 3'd1,
      ST_DEVICE       = 3'd2,
      ST_CABLE        = 3'd3,
      ST_CABLE_DEVICE = 3'd4,
      ST_UNKNOWN      = 3'd5
   } link_state_type;

   typedef enum logic [1:0] {
      SIDE_NONE = 2'd0,
      SIDE_CC1  = 2'd1,
      SIDE_CC2  = 2'd2
   } cc_side_type;

   typedef enum logic [ModeW-1:0] {
      MODE_DEFAULT = 2'd0,
      MODE_1A5     = 2'd1,
      MODE_3A      = 2'd2
   } current_mode_type;

   localparam logic [LevelW-1:0] LVL_BELOW_200  = 2'd0;
   localparam logic [LevelW-1:0] LVL_BELOW_660  = 2'd1;
   localparam logic [LevelW-1:0] LVL_BELOW_1230 = 2'd2;
   localparam logic [LevelW-1:0] LVL_ABOVE_1230 = 2'd3;

   typedef struct packed {
      logic              comp_change_irq;
      logic              level_change_irq;
      logic              comp_level;
      logic [LevelW-1:0] level_cc1;
      logic [LevelW-1:0] level_cc2;
      logic              emarker_present;
   } tick_type;

   typedef struct packed {
      logic [2:0] attach_state;
      logic [1:0] orientation;
      logic       state_changed;
      logic       device_attached;
      logic       cable_attached;
      logic [1:0] pullup_enables;
      logic [1:0] vconn_enables;
      logic [1:0] measure_select;
      logic [1:0] bmc_tx_enables;
   } status_type;

endpackage

// ===== src/tcsam_if.sv =====
// valid/ready channel interfaces for the attach monitor's tick and status words
// no dependencies
interface tcsam_req_if;
   logic       valid;
   logic       ready;
   logic       comp_change_irq;
   logic       level_change_irq;
   logic       comp_level;
   logic [1:0] level_cc1;
   logic [1:0] level_cc2;
   logic       emarker_present;

   modport source (output valid, output comp_change_irq, output level_change_irq,
                   output comp_level, output level_cc1, output level_cc2,
                   output emarker_present, input ready);
   modport sink (input valid, input comp_change_irq, input level_change_irq,
                 input comp_level, input level_cc1, input level_cc2,
                 input emarker_present, output ready);
endinterface

interface tcsam_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] attach_state;
   logic [1:0] orientation;
   logic       state_changed;
   logic       device_attached;
   logic       cable_attached;
   logic [1:0] pullup_enables;
   logic [1:0] vconn_enables;
   logic [1:0] measure_select;
   logic [1:0] bmc_tx_enables;

   modport source (output valid, output attach_state, output orientation,
                   output state_changed, output device_attached, output cable_attached,
                   output pullup_enables, output vconn_enables, output measure_select,
                   output bmc_tx_enables, input ready);
   modport sink (input valid, input attach_state, input orientation,
                 input state_changed, input device_attached, input cable_attached,
                 input pullup_enables, input vconn_enables, input measure_select,
                 input bmc_tx_enables, output ready);
endinterface

// ===== src/typec_source_attach_monitor.sv =====
// USB Type-C source attach monitor, top level: input word register, state and status register
// depends on tcsam_pkg, tcsam_if and tcsam_decide
//
// Takes one tick word (interrupt flags, comparator level, CC1/CC2 BC level codes, e-marker
// answer) per handshake and returns exactly one status word for it: attach state,
// orientation, change flag and the CC switch enables. A word is accepted every cycle while
// the status side keeps taking. The status word is registered: the tick is held in the input
// register, then the status register is written together with the attach state once the
// status side is free. The current_mode register is written through csr_we/csr_wdata and
// should only change while no tick is in flight. Attach state resets to init with unknown
// orientation.
module typec_source_attach_monitor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [tcsam_pkg::ModeW-1:0] csr_wdata,
   tcsam_req_if.sink                   req_chan,
   tcsam_rsp_if.source                 rsp_chan
);
   import tcsam_pkg::*;

   logic [ModeW-1:0] mode_ff;
   logic             in_valid_ff, in_valid_in;
   tick_type         tick_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff;
   link_state_type   state_ff, state_in;
   cc_side_type      side_ff, side_in;
   status_type       status_in;
   logic             out_free, advance, take;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign take     = req_chan.valid && req_chan.ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   tcsam_decide u_decide (
      .tick      (tick_ff),
      .state_cur (state_ff),
      .side_cur  (side_ff),
      .mode      (mode_ff),
      .state_nxt (state_in),
      .side_nxt  (side_in),
      .status    (status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_DEFAULT;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_INIT;
         side_ff      <= SIDE_NONE;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
            side_ff  <= side_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tick_ff.comp_change_irq  <= req_chan.comp_change_irq;
         tick_ff.level_change_irq <= req_chan.level_change_irq;
         tick_ff.comp_level       <= req_chan.comp_level;
         tick_ff.level_cc1        <= req_chan.level_cc1;
         tick_ff.level_cc2        <= req_chan.level_cc2;
         tick_ff.emarker_present  <= req_chan.emarker_present;
      end
      if (advance) begin
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.attach_state    = status_ff.attach_state;
   assign rsp_chan.orientation     = status_ff.orientation;
   assign rsp_chan.state_changed   = status_ff.state_changed;
   assign rsp_chan.device_attached = status_ff.device_attached;
   assign rsp_chan.cable_attached  = status_ff.cable_attached;
   assign rsp_chan.pullup_enables  = status_ff.pullup_enables;
   assign rsp_chan.vconn_enables   = status_ff.vconn_enables;
   assign rsp_chan.measure_select  = status_ff.measure_select;
   assign rsp_chan.bmc_tx_enables  = status_ff.bmc_tx_enables;

endmodule

// ===== src/tcsam_decide.sv =====
// attach decision for one tick: comparator, cable and discovery rules, switch enables
// depends on tcsam_pkg
module tcsam_decide (
   input  tcsam_pkg::tick_type         tick,
   input  tcsam_pkg::link_state_type   state_cur,
   input  tcsam_pkg::cc_side_type      side_cur,
   input  logic [tcsam_pkg::ModeW-1:0] mode,
   output tcsam_pkg::link_state_type   state_nxt,
   output tcsam_pkg::cc_side_type      side_nxt,
   output tcsam_pkg::status_type       status
);
   import tcsam_pkg::*;

   logic [LevelW-1:0] rd, ra, ra_alt;
   logic              c1_rd, c2_rd, c1_nc, c2_nc, c1_ra, c2_ra;
   logic              prev_active, now_cable, sided;
   link_state_type    disc_state, st;
   cc_side_type       disc_side, sd;

   // expected level codes at the advertised current; unused mode acts as default
   always_comb begin
      case (mode)
         MODE_1A5: begin
            rd = LVL_BELOW_1230; ra = LVL_BELOW_200; ra_alt = LVL_BELOW_660;
         end
         MODE_3A: begin
            rd = LVL_ABOVE_1230; ra = LVL_BELOW_660; ra_alt = LVL_BELOW_660;
         end
         default: begin
            rd = LVL_BELOW_660; ra = LVL_BELOW_200; ra_alt = LVL_BELOW_200;
         end
      endcase
   end

   assign c1_rd = tick.level_cc1 == rd;
   assign c2_rd = tick.level_cc2 == rd;
   assign c1_nc = tick.level_cc1 == LVL_ABOVE_1230;
   assign c2_nc = tick.level_cc2 == LVL_ABOVE_1230;
   assign c1_ra = (tick.level_cc1 == ra) || (tick.level_cc1 == ra_alt);
   assign c2_ra = (tick.level_cc2 == ra) || (tick.level_cc2 == ra_alt);

   // priority order: device, cable plus device, cable only
   always_comb begin
      if (c1_rd && c2_nc) begin
         disc_side = SIDE_CC1; disc_state = ST_DEVICE;
      end else if (c2_rd && c1_nc) begin
         disc_side = SIDE_CC2; disc_state = ST_DEVICE;
      end else if (c1_rd && c2_ra) begin
         disc_side = SIDE_CC1; disc_state = ST_CABLE_DEVICE;
      end else if (c2_rd && c1_ra) begin
         disc_side = SIDE_CC2; disc_state = ST_CABLE_DEVICE;
      end else if (c1_nc && c2_ra) begin
         disc_side = SIDE_CC1; disc_state = ST_CABLE;
      end else if (c2_nc && c1_ra) begin
         disc_side = SIDE_CC2; disc_state = ST_CABLE;
      end else begin
         disc_side = SIDE_NONE; disc_state = ST_UNKNOWN;
      end
   end

   assign prev_active = (state_cur == ST_CABLE) || (state_cur == ST_CABLE_DEVICE);

   always_comb begin
      st = state_cur;
      sd = side_cur;
      if (tick.comp_change_irq || tick.level_change_irq || state_cur == ST_INIT) begin
         if (tick.comp_level) begin
            if (prev_active) begin
               st = ST_CABLE;
            end else begin
               st = ST_DETACHED; sd = SIDE_NONE;
            end
         end else if (prev_active) begin
            st = ST_CABLE_DEVICE;
         end else begin
            st = disc_state; sd = disc_side;
         end
      end
      // an active cable that stops answering the ping is gone
      if (prev_active && !tick.emarker_present) begin
         st = ST_DETACHED; sd = SIDE_NONE;
      end
   end

   assign state_nxt = st;
   assign side_nxt  = sd;
   assign now_cable = (st == ST_CABLE) || (st == ST_CABLE_DEVICE);
   assign sided     = (sd == SIDE_CC1) || (sd == SIDE_CC2);

   always_comb begin
      status.attach_state    = st;
      status.orientation     = sd;
      status.state_changed   = st != state_cur;
      status.device_attached = (st == ST_DEVICE) || (st == ST_CABLE_DEVICE);
      status.cable_attached  = now_cable;
      status.pullup_enables  = 2'b11;
      status.vconn_enables   = 2'b00;
      status.measure_select  = 2'b01;
      status.bmc_tx_enables  = 2'b00;
      if (st == ST_DEVICE && sided) begin
         status.pullup_enables = sd;
         status.measure_select = sd;
      end else if (now_cable && sided) begin
         status.pullup_enables = sd;
         status.measure_select = sd;
         status.bmc_tx_enables = sd;
         status.vconn_enables  = ~sd;
      end
   end

endmodule
